FILE: rtl/assert_macros.svh
// Assertion helpers for the scm_checker module.
// Each property is clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cond_a implies cond_c at the same edge.
`define ASSERT_IMP(label, clk, rst_n, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cond_a implies cond_c.
`define ASSERT_NXT(label, clk, rst_n, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_c)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Constants, register indexes and the conditional-mark pattern table for the
// 3x3 shrink conditional-mark block.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Frame limits and derived widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Port field widths
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 10;
  localparam int WIN_W      = 9;

  // Smallest frame edge
  localparam int MIN_SIZE   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Conditional-mark patterns, bonds 1 to 10. One octal digit per window row,
  // top row first, left column in the high bit of each digit.
  localparam int PATTERN_COUNT = 58;
  localparam logic [WIN_W-1:0] MARK_PATTERNS [PATTERN_COUNT] = '{
    9'o120, 9'o420, 9'o024, 9'o021,
    9'o030, 9'o220, 9'o060, 9'o022,
    9'o130, 9'o320, 9'o620, 9'o460, 9'o064, 9'o026, 9'o023, 9'o031,
    9'o131, 9'o720, 9'o464, 9'o027,
    9'o630, 9'o231, 9'o360, 9'o132, 9'o330, 9'o660, 9'o066, 9'o033,
    9'o631, 9'o364, 9'o730, 9'o331, 9'o760, 9'o664, 9'o466, 9'o067, 9'o037, 9'o133,
    9'o731, 9'o764, 9'o467, 9'o137,
    9'o333, 9'o770, 9'o666, 9'o077,
    9'o733, 9'o337, 9'o774, 9'o771, 9'o766, 9'o667, 9'o477, 9'o177,
    9'o737, 9'o775, 9'o767, 9'o577
  };

  // Window matches any pattern; centre must be foreground
  function automatic logic mark_match(logic [WIN_W-1:0] win);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      if (MARK_PATTERNS[i] == win) hit = 1'b1;
    end
    return hit & win[4];
  endfunction

  // Last index of a frame edge, size clamped to MIN_SIZE..max_size
  function automatic int last_index(logic [CFG_W-1:0] size, int max_size);
    int v;
    v = int'(size);
    if (v < MIN_SIZE) return MIN_SIZE - 1;
    else if (v > max_size) return max_size - 1;
    else return v - 1;
  endfunction

endpackage

FILE: rtl/scm_ram.sv
// ----------------------------------------------------------------------------
// scm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Read during a write to the same address returns the old data.
// ----------------------------------------------------------------------------
module scm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/shrink_conditional_mark.sv
// Latency: a result is valid in the cycle after its pixel is accepted.
// Throughput: one pixel per cycle while in_stall is low; the line-store RAM is read
// one column ahead so its registered read data is ready when the pixel arrives.
// Reset: control clears at once, then a sweep zeroes the line store, one
// column per cycle, all MAX_WIDTH (1024) columns, with in_stall high.
// ----------------------------------------------------------------------------
// shrink_conditional_mark
// Raster-order binary pixels in, one conditional-mark result out for every
// interior centre pixel. Two line stores (packed into one 2-bit RAM) and a
// two-column window register form the 3x3 neighbourhood.
// ----------------------------------------------------------------------------
module shrink_conditional_mark (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pixel_bit,
  // mark output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_mark_bit,
  output logic [scm_pkg::COORD_W-1:0]    out_row,
  output logic [scm_pkg::COORD_W-1:0]    out_col,
  output logic                           out_frame_last,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scm_pkg::CFG_W-1:0]      cfg_data
);

  import scm_pkg::*;

  // Configuration and position state
  logic [CFG_W-1:0] width_r,  width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r,    col_nxt;
  logic [ROW_W-1:0] row_r,    row_nxt;
  logic [5:0]       win_cols_r;

  // Line-store clearing sweep
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic               mark_r;
  logic [COORD_W-1:0] row_out_r;
  logic [COORD_W-1:0] col_out_r;
  logic               last_r;

  // Datapath
  logic             cfg_we;
  logic             in_acc;
  logic             emit_pos;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic [1:0]       ls_rdata;
  logic [1:0]       ls_wdata;
  logic [COL_W-1:0] ls_waddr;
  logic             ls_we;
  logic [2:0]       col_new;
  logic [WIN_W-1:0] win;
  logic [COL_W-1:0] col_m1;
  logic [ROW_W-1:0] row_m1;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Clamped frame edges
  assign col_last = COL_W'(last_index(width_r, MAX_WIDTH));
  assign row_last = ROW_W'(last_index(height_r, MAX_HEIGHT));

  // A result is produced once two rows and two columns have been seen
  assign emit_pos = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));

  // Hold input during the line-store sweep, or when a new result would overwrite a stalled one
  assign in_stall = clr_busy_r | (out_valid_r & out_stall & emit_pos);
  assign in_acc   = in_valid & ~in_stall;

  // Line store: bit 1 = two rows back, bit 0 = one row back
  assign ls_wdata = clr_busy_r ? 2'b00 : {ls_rdata[0], in_pixel_bit};
  assign ls_waddr = clr_busy_r ? clr_addr_r : col_r;
  assign ls_we    = clr_busy_r | in_acc;

  scm_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (col_nxt),
    .rdata (ls_rdata)
  );

  // 3x3 window: oldest column, previous column, new column
  assign col_new = {ls_rdata[1], ls_rdata[0], in_pixel_bit};
  assign win = {win_cols_r[5], win_cols_r[2], col_new[2],
                win_cols_r[4], win_cols_r[1], col_new[1],
                win_cols_r[3], win_cols_r[0], col_new[0]};
  assign col_m1 = col_r - COL_W'(1);
  assign row_m1 = row_r - ROW_W'(1);

  // Configuration and raster position
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH)  width_nxt  = cfg_data;
      if (cfg_index == REG_IMAGE_HEIGHT) height_nxt = cfg_data;
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end else if (in_acc) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Result valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && emit_pos)        out_valid_nxt = 1'b1;
    else if (!out_stall)           out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_W'(MAX_WIDTH);
      height_r    <= CFG_W'(MAX_HEIGHT);
      col_r       <= '0;
      row_r       <= '0;
      win_cols_r  <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) win_cols_r <= {win_cols_r[2:0], col_new};
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && emit_pos) begin
      mark_r    <= mark_match(win);
      row_out_r <= COORD_W'(row_m1);
      col_out_r <= COORD_W'(col_m1);
      last_r    <= (row_r == row_last) && (col_r == col_last);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mark_bit   = mark_r;
  assign out_row        = row_out_r;
  assign out_col        = col_out_r;
  assign out_frame_last = last_r;

endmodule

FILE: rtl/scm_checker.sv
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks for shrink_conditional_mark, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [scm_pkg::COORD_W-1:0]    out_row,
  input logic [scm_pkg::COORD_W-1:0]    out_col
);

  import scm_pkg::*;

  // A stalled result stays up
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // Interior centres only: never row or column zero
  `ASSERT_IMP(a_interior, clk, rst_n, out_valid, out_row != '0 && out_col != '0)

  // Line-store sweep blocks input right after reset
  `ASSERT_IMP(a_clear_stall, clk, rst_n, $rose(rst_n), in_stall)

  // A fresh result needs a pixel accepted in the cycle before
  `ASSERT_NXT(a_no_invent, clk, rst_n, !out_valid || !out_stall,
              !out_valid || $past(in_valid && !in_stall))

endmodule

bind shrink_conditional_mark scm_checker u_scm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_row   (out_row),
  .out_col   (out_col)
);
